// ===== src/pwsd_pkg.sv =====
// ----------------------------------------------------------------------------
// pwsd_pkg
// shared types and constants for the plaquette winding string detector
// ----------------------------------------------------------------------------
package pwsd_pkg;

    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_COUNT_BITS  = 32;

    localparam int WIND_BITS   = 4;
    localparam int PLANE_BITS  = 2;
    localparam int SIGN_BITS   = 2;
    localparam int OUT_CNT_BITS = 32;

    // winding values that mark a string
    localparam logic signed [WIND_BITS-1:0] WIND_POS_STRING = 4'sd2;
    localparam logic signed [WIND_BITS-1:0] WIND_NEG_STRING = -4'sd2;

    typedef enum logic [SIGN_BITS-1:0] {
        SIGN_NONE = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } string_sign_t;

    // result of one loop edge
    typedef struct packed {
        logic crossing;  // imaginary parts of the endpoints have opposite signs
        logic up;        // cross product comparison favors +1
    } edge_turn_t;

endpackage

// ===== src/pwsd_edge.sv =====
// ----------------------------------------------------------------------------
// pwsd_edge
// real-axis crossing test and turn direction for one plaquette edge
// ----------------------------------------------------------------------------
module pwsd_edge
    import pwsd_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic signed [SAMPLE_BITS-1:0] a_re,
    input  logic signed [SAMPLE_BITS-1:0] a_im,
    input  logic signed [SAMPLE_BITS-1:0] b_re,
    input  logic signed [SAMPLE_BITS-1:0] b_im,
    output edge_turn_t                    turn
);

    localparam int PROD_BITS = 2 * SAMPLE_BITS;

    logic signed [PROD_BITS-1:0] prod_ab;
    logic signed [PROD_BITS-1:0] prod_ba;
    logic                        a_pos;
    logic                        a_neg;
    logic                        b_pos;
    logic                        b_neg;

    assign prod_ab = PROD_BITS'(a_im) * PROD_BITS'(b_re);
    assign prod_ba = PROD_BITS'(a_re) * PROD_BITS'(b_im);

    assign a_neg = a_im[SAMPLE_BITS-1];
    assign b_neg = b_im[SAMPLE_BITS-1];
    assign a_pos = !a_neg && (a_im != '0);
    assign b_pos = !b_neg && (b_im != '0);

    // a zero imaginary part never crosses
    assign turn.crossing = (a_pos && b_neg) || (a_neg && b_pos);
    // equal cross products count as -1
    assign turn.up       = prod_ab > prod_ba;

endmodule

// ===== src/pwsd_count.sv =====
// ----------------------------------------------------------------------------
// pwsd_count
// saturating string and chirality counter update
// ----------------------------------------------------------------------------
module pwsd_count
    import pwsd_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                         clear,
    input  string_sign_t                 sign,
    input  logic        [COUNT_BITS-1:0] count_cur,
    input  logic signed [COUNT_BITS-1:0] chiral_cur,
    output logic        [COUNT_BITS-1:0] count_next,
    output logic signed [COUNT_BITS-1:0] chiral_next
);

    localparam logic        [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic signed [COUNT_BITS-1:0] CHI_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CHI_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    logic        [COUNT_BITS-1:0] count_base;
    logic signed [COUNT_BITS-1:0] chiral_base;

    assign count_base  = clear ? '0 : count_cur;
    assign chiral_base = clear ? '0 : chiral_cur;

    always_comb
    begin
        count_next  = count_base;
        chiral_next = chiral_base;
        case (sign)
            SIGN_POS:
            begin
                if (count_base != CNT_MAX)
                    count_next = count_base + 1'b1;
                if (chiral_base != CHI_MAX)
                    chiral_next = chiral_base + 1'b1;
            end
            SIGN_NEG:
            begin
                if (count_base != CNT_MAX)
                    count_next = count_base + 1'b1;
                if (chiral_base != CHI_MIN)
                    chiral_next = chiral_base - 1'b1;
            end
            default:
            begin
                count_next  = count_base;
                chiral_next = chiral_base;
            end
        endcase
    end

endmodule

// ===== src/plaquette_winding_string_detect.sv =====
// ----------------------------------------------------------------------------
// plaquette_winding_string_detect
// winding number of a four-corner plaquette loop with running string counters
// ----------------------------------------------------------------------------
// path: input register, then result register, to the master side
// throughput: one plaquette per cycle unless m_axis_tready stalls the output
// reset: asynchronous, clears valid flags and both counters to zero
// ----------------------------------------------------------------------------
module plaquette_winding_string_detect
    import pwsd_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // corner0_re, corner0_im, corner1_re, corner1_im,
    // corner2_re, corner2_im, corner3_re, corner3_im
    input  logic [8*SAMPLE_BITS-1:0] s_axis_tdata,
    // clear_counts, plane
    input  logic [2:0]               s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // winding, string_sign, string_count, chiral_sum, zero pad
    output logic [71:0]              m_axis_tdata,
    // plane_out
    output logic [PLANE_BITS-1:0]    m_axis_tuser
);

    localparam int CORNERS = 4;

    logic                          in_valid_reg;
    logic                          clear_reg;
    logic        [PLANE_BITS-1:0]  plane_reg;
    logic signed [SAMPLE_BITS-1:0] re_reg [CORNERS];
    logic signed [SAMPLE_BITS-1:0] im_reg [CORNERS];

    logic                          out_valid_reg;
    logic signed [WIND_BITS-1:0]   wind_reg;
    logic signed [WIND_BITS-1:0]   wind_next;
    string_sign_t                  sign_reg;
    string_sign_t                  sign_next;
    logic        [PLANE_BITS-1:0]  plane_out_reg;
    logic        [COUNT_BITS-1:0]  count_reg;
    logic        [COUNT_BITS-1:0]  count_next;
    logic signed [COUNT_BITS-1:0]  chiral_reg;
    logic signed [COUNT_BITS-1:0]  chiral_next;

    logic                          accept;
    logic                          advance;
    edge_turn_t                    turn [CORNERS];

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            clear_reg <= s_axis_tuser[0];
            plane_reg <= s_axis_tuser[2:1];
            for (int k = 0; k < CORNERS; k++)
            begin
                re_reg[k] <= s_axis_tdata[2*k*SAMPLE_BITS +: SAMPLE_BITS];
                im_reg[k] <= s_axis_tdata[(2*k+1)*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    // edges a0->a1, a1->a2, a2->a3, a3->a0
    for (genvar k = 0; k < CORNERS; k++)
    begin : g_edge
        localparam int NXT = (k + 1) % CORNERS;
        pwsd_edge #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_edge (
            .a_re (re_reg[k]),
            .a_im (im_reg[k]),
            .b_re (re_reg[NXT]),
            .b_im (im_reg[NXT]),
            .turn (turn[k])
        );
    end

    always_comb
    begin
        wind_next = '0;
        for (int k = 0; k < CORNERS; k++)
        begin
            if (turn[k].crossing)
                wind_next = turn[k].up ? wind_next + 4'sd1 : wind_next - 4'sd1;
        end
        if (wind_next == WIND_POS_STRING)
            sign_next = SIGN_POS;
        else if (wind_next == WIND_NEG_STRING)
            sign_next = SIGN_NEG;
        else
            sign_next = SIGN_NONE;
    end

    pwsd_count #(
        .COUNT_BITS (COUNT_BITS)
    ) u_count (
        .clear       (clear_reg),
        .sign        (sign_next),
        .count_cur   (count_reg),
        .chiral_cur  (chiral_reg),
        .count_next  (count_next),
        .chiral_next (chiral_next)
    );

    // result register, counters move only with a finished plaquette
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            chiral_reg    <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
                chiral_reg    <= chiral_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            wind_reg      <= wind_next;
            sign_reg      <= sign_next;
            plane_out_reg <= plane_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = plane_out_reg;
    assign m_axis_tdata  = {2'b00,
                            OUT_CNT_BITS'(signed'(chiral_reg)),
                            OUT_CNT_BITS'(count_reg),
                            sign_reg,
                            wind_reg};

endmodule
